// ===== hdl/imcs_pkg.sv =====
package imcs_pkg;

  // Opcodes of an incoming item
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RXBYTE = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Bus command codes
  localparam logic [2:0] CMD_SEND = 3'd0;
  localparam logic [2:0] CMD_RX_ACK = 3'd2;
  localparam logic [2:0] CMD_RX_NACK = 3'd3;
  localparam logic [2:0] CMD_START = 3'd4;
  localparam logic [2:0] CMD_RESTART = 3'd5;
  localparam logic [2:0] CMD_STOP = 3'd6;

  // Status codes; the nonzero error codes double as error latch values
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BUSY = 3'd1;
  localparam logic [2:0] ST_NACK = 3'd2;
  localparam logic [2:0] ST_ARB = 3'd3;
  localparam logic [2:0] ST_BUS_ERR = 3'd4;

  localparam int LEN_FIELD_W = 16;
  localparam int MAX_RESULTS = 6;
  localparam int CNT_W = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] command_code;
    logic [7:0] data;
    logic [2:0] status_code;
    logic       last;
  } res_t;

endpackage

// ===== hdl/imcs_in_if.sv =====
interface imcs_in_if;
  import imcs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [6:0]             dev_address;
  logic                   read_not_write;
  logic [1:0]             extra_count;
  logic [23:0]            extra_bytes;
  logic [LEN_FIELD_W-1:0] length;
  logic [7:0]             byte_value;
  logic                   nack_seen;
  logic                   arb_lost;
  logic                   bus_fault;

  modport source (
    output valid, opcode, dev_address, read_not_write, extra_count, extra_bytes,
           length, byte_value, nack_seen, arb_lost, bus_fault,
    input  ready
  );

  modport sink (
    input  valid, opcode, dev_address, read_not_write, extra_count, extra_bytes,
           length, byte_value, nack_seen, arb_lost, bus_fault,
    output ready
  );

endinterface

// ===== hdl/imcs_out_if.sv =====
interface imcs_out_if;

  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] command_code;
  logic [7:0] data;
  logic [2:0] status_code;
  logic       last;

  modport source (
    output valid, kind, command_code, data, status_code, last,
    input  ready
  );

  modport sink (
    input  valid, kind, command_code, data, status_code, last,
    output ready
  );

endinterface

// ===== hdl/i2c_master_command_sequencer_core.sv =====
// I2C master transaction sequencer. Each request item (start, write byte,
// received byte, status tick) is decoded in the cycle it is accepted: the
// transaction state updates at that edge and the result items it causes
// (START/SEND/RESTART/RECEIVE/STOP command words, received data, status) are
// loaded into a six-entry result buffer that drains one item per cycle while
// result.ready is high, the final one flagged with last. An item that causes
// zero or one result leaves request.ready high, so such items are taken every
// cycle with the buffer working as the output register; an item that causes
// more results keeps ready low while the buffer drains to its final entry (a
// start with three register-address bytes and a read makes six). Ready also
// drops while a result waits on result.ready. A start during a transaction
// is refused with a busy status. The last read byte is requested with NACK;
// a zero-length transfer issues STOP on the next tick. The first flagged
// error on a tick (nack over arbitration loss over bus fault) is latched
// silently and the next tick closes the transaction with that status.
// LENGTH_BITS sizes the byte counter; larger lengths saturate.
module i2c_master_command_sequencer_core
  import imcs_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  imcs_in_if.sink     request,
  imcs_out_if.source  result
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SEND = 3'd1,
    PH_RECV = 3'd2,
    PH_TERM = 3'd3,
    PH_ERR  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  // Transaction state
  phase_t                 phase, phase_next;
  logic                   busy_flag, busy_flag_next;
  logic [6:0]             target_address, target_address_next;
  logic                   reading, reading_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [2:0]             error_latch, error_latch_next;

  // Result buffer: entry 0 is the head shown on the result channel
  res_t                   rbuf [MAX_RESULTS];
  logic [CNT_W-1:0]       rcount;

  // Results of the item being accepted
  res_t                   rl [MAX_RESULTS];
  logic [CNT_W-1:0]       rl_cnt;

  logic                   accept;
  logic                   take;
  logic [LENGTH_BITS-1:0] len_sat;
  logic [LENGTH_BITS-1:0] bl_dec;
  logic [1:0]             sel;

  assign accept = request.valid && request.ready;
  assign take   = result.valid && result.ready;

  // Take a new item when the buffer is empty or its final entry leaves now
  assign request.ready = (rcount == '0) || ((rcount == CNT_W'(1)) && result.ready);

  assign result.valid        = (rcount != '0);
  assign result.kind         = rbuf[0].kind;
  assign result.command_code = rbuf[0].command_code;
  assign result.data         = rbuf[0].data;
  assign result.status_code  = rbuf[0].status_code;
  assign result.last         = rbuf[0].last;

  // Fit the length field into the byte counter, saturating when it is narrower
  generate
    if (LENGTH_BITS >= LEN_FIELD_W) begin : g_len_wide
      assign len_sat = LENGTH_BITS'(request.length);
    end else begin : g_len_narrow
      assign len_sat = (request.length[LEN_FIELD_W-1:LENGTH_BITS] != '0) ?
                       {LENGTH_BITS{1'b1}} : request.length[LENGTH_BITS-1:0];
    end
  endgenerate

  assign bl_dec = bytes_left - LENGTH_BITS'(1);

  function automatic res_t mk_res(logic [1:0] k, logic [2:0] c, logic [7:0] d,
                                  logic [2:0] s);
    res_t r;
    r.kind         = k;
    r.command_code = c;
    r.data         = d;
    r.status_code  = s;
    r.last         = 1'b0;
    return r;
  endfunction

  // Request the final byte with NACK
  function automatic logic [2:0] rx_cmd(logic [LENGTH_BITS-1:0] remaining);
    return (remaining == LENGTH_BITS'(1)) ? CMD_RX_NACK : CMD_RX_ACK;
  endfunction

  always_comb begin
    phase_next          = phase;
    busy_flag_next      = busy_flag;
    target_address_next = target_address;
    reading_next        = reading;
    bytes_left_next     = bytes_left;
    error_latch_next    = error_latch;
    rl_cnt              = '0;
    sel                 = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      rl[i] = '0;
    end

    unique case (request.opcode)
      OP_START: begin
        if (busy_flag) begin
          rl[rl_cnt] = mk_res(KIND_STATUS, CMD_SEND, 8'd0, ST_BUSY);
          rl_cnt     = rl_cnt + CNT_W'(1);
        end else begin
          target_address_next = request.dev_address;
          reading_next        = request.read_not_write;
          bytes_left_next     = len_sat;
          error_latch_next    = ST_OK;
          busy_flag_next      = 1'b1;
          if (request.extra_count != 2'd0) begin
            rl[rl_cnt] = mk_res(KIND_CMD, CMD_START, {request.dev_address, 1'b0}, ST_OK);
            rl_cnt     = rl_cnt + CNT_W'(1);
            // Send register address bytes, most significant first
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < request.extra_count) begin
                sel        = request.extra_count - 2'd1 - 2'(i);
                rl[rl_cnt] = mk_res(KIND_CMD, CMD_SEND, request.extra_bytes[sel*8 +: 8],
                                    ST_OK);
                rl_cnt     = rl_cnt + CNT_W'(1);
              end
            end
            if (request.read_not_write) begin
              rl[rl_cnt] = mk_res(KIND_CMD, CMD_RESTART, {request.dev_address, 1'b1},
                                  ST_OK);
              rl_cnt     = rl_cnt + CNT_W'(1);
            end
          end else begin
            rl[rl_cnt] = mk_res(KIND_CMD, CMD_START,
                                {request.dev_address, request.read_not_write}, ST_OK);
            rl_cnt     = rl_cnt + CNT_W'(1);
          end
          if (request.read_not_write) begin
            if (len_sat != '0) begin
              rl[rl_cnt] = mk_res(KIND_CMD, rx_cmd(len_sat), 8'd0, ST_OK);
              rl_cnt     = rl_cnt + CNT_W'(1);
            end
            phase_next = PH_RECV;
          end else begin
            phase_next = PH_SEND;
          end
        end
      end
      OP_WRITE: begin
        if (busy_flag && (phase == PH_SEND) && (bytes_left != '0)) begin
          rl[rl_cnt]      = mk_res(KIND_CMD, CMD_SEND, request.byte_value, ST_OK);
          rl_cnt          = rl_cnt + CNT_W'(1);
          bytes_left_next = bl_dec;
          if (bl_dec == '0) begin
            rl[rl_cnt] = mk_res(KIND_CMD, CMD_STOP, 8'd0, ST_OK);
            rl_cnt     = rl_cnt + CNT_W'(1);
            phase_next = PH_TERM;
          end
        end
      end
      OP_RXBYTE: begin
        if (busy_flag && (phase == PH_RECV) && (bytes_left != '0)) begin
          rl[rl_cnt]      = mk_res(KIND_DATA, CMD_SEND, request.byte_value, ST_OK);
          rl_cnt          = rl_cnt + CNT_W'(1);
          bytes_left_next = bl_dec;
          if (bl_dec != '0) begin
            rl[rl_cnt] = mk_res(KIND_CMD, rx_cmd(bl_dec), 8'd0, ST_OK);
            rl_cnt     = rl_cnt + CNT_W'(1);
          end else begin
            rl[rl_cnt] = mk_res(KIND_CMD, CMD_STOP, 8'd0, ST_OK);
            rl_cnt     = rl_cnt + CNT_W'(1);
            phase_next = PH_TERM;
          end
        end
      end
      OP_TICK: begin
        if (busy_flag) begin
          if ((error_latch == ST_OK) &&
              (request.nack_seen || request.arb_lost || request.bus_fault)) begin
            // Latch the first error silently; the next tick reports it
            priority if (request.nack_seen) error_latch_next = ST_NACK;
            else if (request.arb_lost)      error_latch_next = ST_ARB;
            else                            error_latch_next = ST_BUS_ERR;
            phase_next = PH_ERR;
          end else if (((phase == PH_SEND) || (phase == PH_RECV)) && (bytes_left == '0)) begin
            rl[rl_cnt] = mk_res(KIND_CMD, CMD_STOP, 8'd0, ST_OK);
            rl_cnt     = rl_cnt + CNT_W'(1);
            phase_next = PH_TERM;
          end else if ((phase == PH_TERM) || (phase == PH_ERR)) begin
            rl[rl_cnt]     = mk_res(KIND_STATUS, CMD_SEND, 8'd0, error_latch);
            rl_cnt         = rl_cnt + CNT_W'(1);
            busy_flag_next = 1'b0;
            phase_next     = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    // Flag the final result of this item
    if (rl_cnt != '0) begin
      rl[rl_cnt - CNT_W'(1)].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      busy_flag      <= 1'b0;
      target_address <= '0;
      reading        <= 1'b0;
      bytes_left     <= '0;
      error_latch    <= ST_OK;
      rcount         <= '0;
    end else begin
      if (accept) begin
        // Advance the transaction and load this item's results
        phase          <= phase_next;
        busy_flag      <= busy_flag_next;
        target_address <= target_address_next;
        reading        <= reading_next;
        bytes_left     <= bytes_left_next;
        error_latch    <= error_latch_next;
        rcount         <= rl_cnt;
        for (int i = 0; i < MAX_RESULTS; i++) begin
          rbuf[i] <= rl[i];
        end
      end else if (take) begin
        // Drop the head and shift the rest forward
        rcount <= rcount - CNT_W'(1);
        for (int i = 0; i < MAX_RESULTS - 1; i++) begin
          rbuf[i] <= rbuf[i + 1];
        end
      end
    end
  end

  // Never take an item while more than one result is still queued
  a_no_accept_while_queued: assert property (@(posedge clk) disable iff (rst)
    (rcount > CNT_W'(1)) |-> !request.ready)
    else $error("request taken with results still queued");

  // The head carries last exactly when it is the only queued result
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (rcount != '0) |-> (rbuf[0].last == (rcount == CNT_W'(1))))
    else $error("last flag out of place in result buffer");

  // An idle sequencer sits in idle or done
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    !busy_flag |-> ((phase == PH_IDLE) || (phase == PH_DONE)))
    else $error("phase active while not busy");

  // A latched error during a transaction parks the sequencer in error wait
  a_error_wait: assert property (@(posedge clk) disable iff (rst)
    (busy_flag && (error_latch != ST_OK)) |-> (phase == PH_ERR))
    else $error("error latched outside error wait");

  // A start taken while idle opens a transaction
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.opcode == OP_START) && !busy_flag) |=> busy_flag)
    else $error("start did not open a transaction");

endmodule

// ===== tb/sv/imcs_result_checker.sv =====
`timescale 1ns / 100ps

module imcs_result_checker
  import imcs_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  imcs_in_if   request,
  imcs_out_if  result,
  output int   failures,
  output int   outstanding,
  output int   requests_seen,
  output int   results_seen,
  output int   statuses_seen
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SEND, PH_RECV, PH_TERM, PH_ERR, PH_DONE
  } phase_t;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

  phase_t               ph;
  logic                 busy;
  logic [6:0]           target;
  logic                 rd;
  logic [LENGTH_BITS-1:0] remaining;
  logic [2:0]           err;

  res_t awaited[$];
  int   mistakes;
  int   n_req, n_res, n_st;

  function automatic res_t word(input logic [1:0] kind, input logic [2:0] cmd,
                                input logic [7:0] data, input logic [2:0] st);
    res_t w;
    w.kind = kind;
    w.command_code = cmd;
    w.data = data;
    w.status_code = st;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic logic [2:0] rx_request(input logic [LENGTH_BITS-1:0] left);
    return (left == 1) ? CMD_RX_NACK : CMD_RX_ACK;
  endfunction

  // Advance the transaction state by one request item and queue its results.
  function automatic void sequence_commands(
    input logic [1:0] op, input logic [6:0] addr, input logic rnw,
    input logic [1:0] cnt, input logic [23:0] extra, input logic [15:0] len,
    input logic [7:0] bval, input logic nack, input logic arb, input logic fault);
    res_t batch[MAX_RESULTS];
    int n;
    bit fresh;
    longint unsigned span;
    n = 0;
    fresh = 1'b0;
    case (op)
      OP_START: begin
        if (busy) begin
          batch[n] = word(KIND_STATUS, CMD_NONE, 8'h00, ST_BUSY);
          n++;
        end else begin
          target = addr;
          rd = rnw;
          span = 64'(len);
          if (span > LEN_MAX) span = LEN_MAX;
          remaining = span[LENGTH_BITS-1:0];
          err = ST_OK;
          busy = 1'b1;
          if (cnt != 2'd0) begin
            batch[n] = word(KIND_CMD, CMD_START, {addr, 1'b0}, ST_OK);
            n++;
            for (int i = int'(cnt) - 1; i >= 0; i--) begin
              batch[n] = word(KIND_CMD, CMD_SEND, extra[8*i +: 8], ST_OK);
              n++;
            end
            if (rnw) begin
              batch[n] = word(KIND_CMD, CMD_RESTART, {addr, 1'b1}, ST_OK);
              n++;
            end
          end else begin
            batch[n] = word(KIND_CMD, CMD_START, {addr, rnw}, ST_OK);
            n++;
          end
          if (rnw) begin
            if (remaining != 0) begin
              batch[n] = word(KIND_CMD, rx_request(remaining), 8'h00, ST_OK);
              n++;
            end
            ph = PH_RECV;
          end else begin
            ph = PH_SEND;
          end
        end
      end
      OP_WRITE: begin
        if (busy && ph == PH_SEND && remaining != 0) begin
          batch[n] = word(KIND_CMD, CMD_SEND, bval, ST_OK);
          n++;
          remaining--;
          if (remaining == 0) begin
            batch[n] = word(KIND_CMD, CMD_STOP, 8'h00, ST_OK);
            n++;
            ph = PH_TERM;
          end
        end
      end
      OP_RXBYTE: begin
        if (busy && ph == PH_RECV && remaining != 0) begin
          batch[n] = word(KIND_DATA, CMD_NONE, bval, ST_OK);
          n++;
          remaining--;
          if (remaining != 0) begin
            batch[n] = word(KIND_CMD, rx_request(remaining), 8'h00, ST_OK);
            n++;
          end else begin
            batch[n] = word(KIND_CMD, CMD_STOP, 8'h00, ST_OK);
            n++;
            ph = PH_TERM;
          end
        end
      end
      default: begin
        if (busy) begin
          // Latch the first error only; nack wins over arbitration over bus fault.
          if (err == ST_OK) begin
            if (nack) err = ST_NACK;
            else if (arb) err = ST_ARB;
            else if (fault) err = ST_BUS_ERR;
            if (err != ST_OK) begin
              ph = PH_ERR;
              fresh = 1'b1;
            end
          end
          if (!fresh) begin
            if ((ph == PH_SEND || ph == PH_RECV) && remaining == 0) begin
              batch[n] = word(KIND_CMD, CMD_STOP, 8'h00, ST_OK);
              n++;
              ph = PH_TERM;
            end else if (ph == PH_TERM || ph == PH_ERR) begin
              batch[n] = word(KIND_STATUS, CMD_NONE, 8'h00, err);
              n++;
              busy = 1'b0;
              ph = PH_DONE;
            end
          end
        end
      end
    endcase
    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin : watch
    res_t got, want;
    if (rst) begin
      ph = PH_IDLE;
      busy = 1'b0;
      target = '0;
      rd = 1'b0;
      remaining = '0;
      err = ST_OK;
      awaited.delete();
      mistakes = 0;
      n_req = 0;
      n_res = 0;
      n_st = 0;
    end else begin
      // Check the outgoing item first: it can only belong to an earlier request.
      if (result.valid && result.ready) begin
        got.kind = result.kind;
        got.command_code = result.command_code;
        got.data = result.data;
        got.status_code = result.status_code;
        got.last = result.last;
        n_res++;
        if (got.kind == KIND_STATUS) n_st++;
        if (awaited.size() == 0) begin
          mistakes++;
          if (mistakes <= 10)
            $display("%0t: unexpected result kind=%0d cmd=%0d data=%02h st=%0d last=%0d",
                     $time, got.kind, got.command_code, got.data, got.status_code, got.last);
        end else begin
          want = awaited.pop_front();
          if (got.kind !== want.kind || got.command_code !== want.command_code ||
              got.data !== want.data || got.status_code !== want.status_code ||
              got.last !== want.last) begin
            mistakes++;
            if (mistakes <= 10) begin
              $write("%0t: mismatch exp kind=%0d cmd=%0d data=%02h st=%0d last=%0d, ",
                     $time, want.kind, want.command_code, want.data, want.status_code,
                     want.last);
              $display("got kind=%0d cmd=%0d data=%02h st=%0d last=%0d",
                       got.kind, got.command_code, got.data, got.status_code, got.last);
            end
          end
        end
      end
      if (request.valid && request.ready) begin
        n_req++;
        sequence_commands(request.opcode, request.dev_address, request.read_not_write,
                          request.extra_count, request.extra_bytes, request.length,
                          request.byte_value, request.nack_seen, request.arb_lost,
                          request.bus_fault);
      end
    end
    failures <= mistakes;
    outstanding <= awaited.size();
    requests_seen <= n_req;
    results_seen <= n_res;
    statuses_seen <= n_st;
  end

endmodule

// ===== tb/sv/tb_i2c_master_command_sequencer_core.sv =====
`timescale 1ns / 100ps

module tb_i2c_master_command_sequencer_core;
  import imcs_pkg::*;

  // Cycles with no item moved on either channel before the run is declared hung.
  localparam int IDLE_LIMIT = 3000;
  // Settle time after the last expected result.
  localparam int TAIL_CYCLES = 16;
  // Stop generating once this many request items of any kind have gone in.
  localparam int ITEM_TARGET = 380;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  dev_address;
    logic        read_not_write;
    logic [1:0]  extra_count;
    logic [23:0] extra_bytes;
    logic [15:0] length;
    logic [7:0]  byte_value;
    logic        nack_seen;
    logic        arb_lost;
    logic        bus_fault;
  } request_t;

  logic clk;
  logic rst;

  imcs_in_if  request ();
  imcs_out_if result ();

  int failures;
  int outstanding;
  int requests_seen;
  int results_seen;
  int statuses_seen;

  int items_sent;
  int idle_cycles;
  int sink_wait;
  bit src_calm;
  bit snk_calm;

  i2c_master_command_sequencer_core u_top (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result)
  );

  imcs_result_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .result        (result),
    .failures      (failures),
    .outstanding   (outstanding),
    .requests_seen (requests_seen),
    .results_seen  (results_seen),
    .statuses_seen (statuses_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random content for every field; callers override what matters to them.
  function automatic request_t filler();
    logic [63:0] noise;
    noise = {$urandom(), $urandom()};
    return noise[62:0];
  endfunction

  function automatic request_t start_item(input logic [6:0] addr, input logic rnw,
                                          input logic [1:0] cnt, input logic [23:0] extra,
                                          input logic [15:0] len);
    request_t it;
    it = filler();
    it.opcode = OP_START;
    it.dev_address = addr;
    it.read_not_write = rnw;
    it.extra_count = cnt;
    it.extra_bytes = extra;
    it.length = len;
    return it;
  endfunction

  function automatic request_t byte_item(input logic [1:0] op, input logic [7:0] value);
    request_t it;
    it = filler();
    it.opcode = op;
    it.byte_value = value;
    return it;
  endfunction

  function automatic request_t tick_item(input logic nack, input logic arb,
                                         input logic fault);
    request_t it;
    it = filler();
    it.opcode = OP_TICK;
    it.nack_seen = nack;
    it.arb_lost = arb;
    it.bus_fault = fault;
    return it;
  endfunction

  // Tick with at least one error flag raised.
  function automatic request_t error_tick();
    logic [2:0] flags;
    flags = 3'($urandom_range(1, 7));
    return tick_item(flags[2], flags[1], flags[0]);
  endfunction

  // Mostly clean tick; now and then one that raises an error instead.
  function automatic request_t closing_tick();
    if ($urandom_range(0, 5) == 0) return error_tick();
    return tick_item(1'b0, 1'b0, 1'b0);
  endfunction

  // Hold valid low for a random gap, then present the item and wait for it to be taken.
  task automatic send(input request_t it, input bit counted);
    int gap;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      request.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    request.opcode = it.opcode;
    request.dev_address = it.dev_address;
    request.read_not_write = it.read_not_write;
    request.extra_count = it.extra_count;
    request.extra_bytes = it.extra_bytes;
    request.length = it.length;
    request.byte_value = it.byte_value;
    request.nack_seen = it.nack_seen;
    request.arb_lost = it.arb_lost;
    request.bus_fault = it.bus_fault;
    request.valid = 1'b1;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    if (counted) items_sent++;
  endtask

  // Drop valid and hold off until every expected result has been taken.
  task automatic drain();
    @(negedge clk);
    request.valid = 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Items that should change nothing, except a start while busy which is refused.
  task automatic disturb(input bit rnw);
    case ($urandom_range(0, 2))
      0: send(byte_item(rnw ? OP_WRITE : OP_RXBYTE, 8'h5A), 1'b0);
      1: send(tick_item(1'b0, 1'b0, 1'b0), 1'b0);
      default: begin
        request_t it;
        it = filler();
        it.opcode = OP_START;
        send(it, 1'b1);
      end
    endcase
  endtask

  // One well-formed transaction with random content, possibly aborted by an error.
  task automatic random_transaction();
    request_t it;
    logic [31:0] draw;
    logic [15:0] len;
    int stop_at;
    bit rnw;
    bit faulted;
    draw = $urandom();
    if ($urandom_range(0, 19) == 0) len = draw[15:0];
    else len = draw[15:0] % 16'd7;
    stop_at = -1;
    if (len > 16'd6) stop_at = $urandom_range(0, 4);
    else if ($urandom_range(0, 5) == 0) stop_at = $urandom_range(0, len);
    it = filler();
    it.opcode = OP_START;
    it.length = len;
    rnw = it.read_not_write;
    send(it, 1'b1);
    faulted = 1'b0;
    for (int k = 0; k < int'(len) && !faulted; k++) begin
      if (k == stop_at) begin
        send(error_tick(), 1'b1);
        faulted = 1'b1;
      end else begin
        if ($urandom_range(0, 9) == 0) disturb(rnw);
        it = filler();
        it.opcode = rnw ? OP_RXBYTE : OP_WRITE;
        send(it, 1'b1);
      end
    end
    // A zero-length transfer needs a tick for its STOP before the closing tick.
    if (!faulted && len == 16'd0) begin
      it = closing_tick();
      send(it, 1'b1);
      faulted = it.nack_seen | it.arb_lost | it.bus_fault;
    end
    if (!faulted) begin
      it = closing_tick();
      send(it, 1'b1);
      faulted = it.nack_seen | it.arb_lost | it.bus_fault;
    end
    if (faulted) send(filler() | request_t'({2'b11, 61'd0}), 1'b1);
  endtask

  // Fully random items, then two faulting ticks that close whatever is open.
  task automatic random_burst();
    request_t it;
    repeat ($urandom_range(4, 10)) begin
      it = filler();
      if ($urandom_range(0, 3) != 0) it.length = {13'd0, it.length[2:0]};
      send(it, 1'b0);
    end
    repeat (2)
      send(tick_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1), 1'b0);
  endtask

  task automatic directed_checks();
    // Nothing open: tick and stray write are ignored.
    send(tick_item(1'b1, 1'b1, 1'b1), 1'b0);
    send(byte_item(OP_WRITE, 8'h3C), 1'b0);
    // Write of two bytes to the top address, with a refused start in between.
    send(start_item(7'h7F, 1'b0, 2'd0, 24'h000000, 16'd2), 1'b1);
    send(start_item(7'h00, 1'b1, 2'd3, 24'hFFFFFF, 16'hFFFF), 1'b1);
    send(byte_item(OP_WRITE, 8'h00), 1'b1);
    send(byte_item(OP_WRITE, 8'hFF), 1'b1);
    send(byte_item(OP_WRITE, 8'h11), 1'b0);
    send(tick_item(1'b0, 1'b0, 1'b0), 1'b1);
    // Read of one byte behind three register bytes: six results, NACK on the only byte.
    send(start_item(7'h00, 1'b1, 2'd3, 24'hA5C30F, 16'd1), 1'b1);
    send(byte_item(OP_RXBYTE, 8'hFF), 1'b1);
    send(tick_item(1'b0, 1'b0, 1'b0), 1'b1);
    // Zero-length write and read: STOP comes on the next tick.
    send(start_item(7'h55, 1'b0, 2'd1, 24'h0000E7, 16'd0), 1'b1);
    send(tick_item(1'b0, 1'b0, 1'b0), 1'b1);
    send(tick_item(1'b0, 1'b0, 1'b0), 1'b1);
    send(start_item(7'h2A, 1'b1, 2'd2, 24'h00BEEF, 16'd0), 1'b1);
    send(tick_item(1'b0, 1'b0, 1'b0), 1'b1);
    send(tick_item(1'b0, 1'b0, 1'b0), 1'b1);
    // All flags at once: nack wins, no STOP, next tick reports it.
    send(start_item(7'h13, 1'b1, 2'd0, 24'h000000, 16'd3), 1'b1);
    send(tick_item(1'b1, 1'b1, 1'b1), 1'b1);
    send(tick_item(1'b0, 1'b0, 1'b0), 1'b1);
    // Longest length, aborted by arbitration loss over bus fault.
    send(start_item(7'h6C, 1'b0, 2'd0, 24'h000000, 16'hFFFF), 1'b1);
    send(tick_item(1'b0, 1'b1, 1'b1), 1'b1);
    send(tick_item(1'b1, 1'b0, 1'b0), 1'b1);
    // Bus fault after STOP still latches and closes with bus error.
    send(start_item(7'h01, 1'b0, 2'd0, 24'h000000, 16'd1), 1'b1);
    send(byte_item(OP_WRITE, 8'h81), 1'b1);
    send(tick_item(1'b0, 1'b0, 1'b1), 1'b1);
    send(tick_item(1'b0, 1'b0, 1'b0), 1'b1);
    drain();
  endtask

  // Stimulus: reset, directed cases, then random transactions until the target.
  initial begin
    rst = 1'b1;
    items_sent = 0;
    src_calm = 1'b0;
    request.valid = 1'b0;
    request.opcode = OP_TICK;
    request.dev_address = '0;
    request.read_not_write = 1'b0;
    request.extra_count = '0;
    request.extra_bytes = '0;
    request.length = '0;
    request.byte_value = '0;
    request.nack_seen = 1'b0;
    request.arb_lost = 1'b0;
    request.bus_fault = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    directed_checks();

    while (requests_seen < ITEM_TARGET) begin
      case ($urandom_range(0, 24))
        0, 1: random_burst();
        2: drain();
        default: random_transaction();
      endcase
    end

    // Wait for the last results, then let the block settle.
    @(negedge clk);
    request.valid = 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d request items (%0d sequenced), checked %0d result items",
             requests_seen, items_sent, results_seen);
    $display("Closed %0d transactions or refusals by status, %0d mismatches",
             statuses_seen, failures);
    if (failures == 0) begin
      $display("tb_i2c_master_command_sequencer_core: PASS");
    end else begin
      $display("tb_i2c_master_command_sequencer_core: FAIL");
    end
    $finish;
  end

  // Result side: stall a random number of cycles before taking each item,
  // with calm stretches where ready stays high.
  initial begin
    result.ready = 1'b0;
    sink_wait = 0;
    snk_calm = 1'b0;
    forever begin
      @(posedge clk);
      if (result.valid && result.ready) begin
        if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
        sink_wait = snk_calm ? 0 : $urandom_range(0, 13);
      end
      @(negedge clk);
      if (rst) begin
        result.ready = 1'b0;
      end else if (sink_wait > 0) begin
        result.ready = 1'b0;
        sink_wait--;
      end else begin
        result.ready = 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_i2c_master_command_sequencer_core: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
